// ----- rtl/core/console_activation_gate_macros.svh -----
// ----------------------------------------------------------------------------
// Console activation gate assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_ACTIVATION_GATE_MACROS_SVH
`define CONSOLE_ACTIVATION_GATE_MACROS_SVH

// Same-cycle implication.
`define CAG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cag_pkg.sv -----
// ----------------------------------------------------------------------------
// Console activation gate package
// Transaction types, configuration register layout and byte constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cag_pkg;

  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;

  typedef enum logic [2:0] {
    REG_DEBOUNCE  = 3'd0,
    REG_WINDOW    = 3'd1,
    REG_INACTIVE  = 3'd2,
    REG_MASK_LOW  = 3'd3,
    REG_MASK_HIGH = 3'd4
  } cag_reg_t;

  typedef enum logic [2:0] {
    ACT_IGNORED     = 3'd0,
    ACT_FIRST_ENTER = 3'd1,
    ACT_ACTIVATED   = 3'd2,
    ACT_RESTART     = 3'd3,
    ACT_DISPATCH    = 3'd4,
    ACT_SELECT      = 3'd5,
    ACT_BAD_DEVICE  = 3'd6
  } cag_action_t;

  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;
  localparam logic [7:0] DIGIT_LO = 8'h31;
  localparam logic [7:0] DIGIT_HI = 8'h39;

  localparam logic [15:0] DEBOUNCE_RST = 16'd100;
  localparam logic [15:0] WINDOW_RST   = 16'd1500;
  localparam logic [31:0] INACTIVE_RST = 32'd300000;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] enter_window_ms;
    logic [31:0] inactivity_limit_ms;
    logic [63:0] key_mask_low;
    logic [63:0] key_mask_high;
  } cag_cfg_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    logic [7:0]  device_count;
  } cag_in_item_t;

  typedef struct packed {
    cag_action_t action;
    logic        accepted;
    logic [6:0]  key_code;
    logic [3:0]  device_index;
    logic        auto_deactivated;
  } cag_out_item_t;

endpackage

// ----- rtl/core/cag_stream_if.sv -----
// ----------------------------------------------------------------------------
// Console activation gate stream interface
// Valid/ready channel carrying one transaction payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cag_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/core/cag_decide.sv -----
// ----------------------------------------------------------------------------
// Console activation gate decision logic
// Single-pass result and next-state computation for one received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cag_decide #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  cag_pkg::cag_cfg_t      cfg,
  input  cag_pkg::cag_in_item_t  item,
  input  logic                   active,
  input  logic [TIME_WIDTH-1:0]  last_act,
  input  logic [TIME_WIDTH-1:0]  first_enter,
  input  logic [TIME_WIDTH-1:0]  last_enter,
  output cag_pkg::cag_out_item_t res,
  output logic                   active_nxt,
  output logic [TIME_WIDTH-1:0]  last_act_nxt,
  output logic [TIME_WIDTH-1:0]  first_enter_nxt,
  output logic [TIME_WIDTH-1:0]  last_enter_nxt
);

  localparam int unsigned CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] el_act;
  logic [TIME_WIDTH-1:0] el_first;
  logic [TIME_WIDTH-1:0] el_enter;
  logic                  timed_out;
  logic                  enter;
  logic                  debounced;
  logic                  printable;
  logic                  digit;
  logic                  marked;
  logic [3:0]            dev;
  logic [TIME_WIDTH-1:0] first_mid;

  assign now_t    = TIME_WIDTH'(item.now_ms);
  assign el_act   = now_t - last_act;
  assign el_enter = now_t - last_enter;
  assign el_first = now_t - first_mid;

  assign timed_out = active && (last_act != '0) &&
                     (CMP_W'(el_act) > CMP_W'(cfg.inactivity_limit_ms));
  assign first_mid = timed_out ? '0 : first_enter;

  assign enter     = (item.rx_byte == cag_pkg::BYTE_CR) || (item.rx_byte == cag_pkg::BYTE_LF);
  assign debounced = (last_enter != '0) &&
                     (el_enter < TIME_WIDTH'(cfg.debounce_ms));
  assign printable = (item.rx_byte >= cag_pkg::PRINT_LO) && (item.rx_byte <= cag_pkg::PRINT_HI);
  assign digit     = (item.rx_byte >= cag_pkg::DIGIT_LO) && (item.rx_byte <= cag_pkg::DIGIT_HI);
  assign marked    = item.rx_byte[6] ? cfg.key_mask_high[item.rx_byte[5:0]]
                                     : cfg.key_mask_low[item.rx_byte[5:0]];
  assign dev       = 4'(item.rx_byte - cag_pkg::DIGIT_LO);

  always_comb begin
    res                  = '0;
    res.action           = cag_pkg::ACT_IGNORED;
    res.auto_deactivated = timed_out;
    active_nxt           = active && !timed_out;
    last_act_nxt         = last_act;
    first_enter_nxt      = first_mid;
    last_enter_nxt       = last_enter;
    if (!(active && !timed_out)) begin
      if (enter && !debounced) begin
        last_enter_nxt = now_t;
        res.accepted   = 1'b1;
        if (first_mid == '0) begin
          first_enter_nxt = now_t;
          res.action      = cag_pkg::ACT_FIRST_ENTER;
        end else if (CMP_W'(el_first) <= CMP_W'(cfg.enter_window_ms)) begin
          active_nxt      = 1'b1;
          first_enter_nxt = '0;
          last_act_nxt    = now_t;
          res.action      = cag_pkg::ACT_ACTIVATED;
        end else begin
          first_enter_nxt = now_t;
          res.action      = cag_pkg::ACT_RESTART;
        end
      end
    end else begin
      last_act_nxt = now_t;
      if (!enter && printable) begin
        if (marked) begin
          res.action   = cag_pkg::ACT_DISPATCH;
          res.accepted = 1'b1;
          res.key_code = item.rx_byte[6:0];
        end else if (digit) begin
          res.device_index = dev;
          if (8'(dev) < item.device_count) begin
            res.action   = cag_pkg::ACT_SELECT;
            res.accepted = 1'b1;
          end else begin
            res.action = cag_pkg::ACT_BAD_DEVICE;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/core/console_activation_gate.sv -----
// ----------------------------------------------------------------------------
// Console activation gate
// Serial console noise guard: double-Enter activation, inactivity timeout,
// key dispatch and device selection, one result transaction per byte.
// ----------------------------------------------------------------------------
// Accepts one byte transaction per clock while the output is not stalled and
// returns exactly one result transaction per byte: the byte is captured in
// an input register, decided by one pass of compare logic against the console
// state, and written to a result register. Output back-pressure holds both
// registers and stalls the input channel. Registers sit on an APB port
// with 64-bit data at byte address 8*index; write them only while idle.
// Timestamps wrap modulo 2^TIME_WIDTH and a stored time of zero means none.
`timescale 1ns / 1ps

module console_activation_gate #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  cag_stream_if.sink                  in_ch,
  cag_stream_if.source                out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cag_pkg::ADDR_W-1:0]  paddr,
  input  logic [cag_pkg::DATA_W-1:0]  pwdata,
  output logic [cag_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

`include "console_activation_gate_macros.svh"

  cag_pkg::cag_cfg_t      cfg_r;
  cag_pkg::cag_reg_t      reg_idx;
  logic                   cfg_wr;

  cag_pkg::cag_in_item_t  in_item_r;
  logic                   in_valid_r;
  cag_pkg::cag_out_item_t out_item_r;
  logic                   out_valid_r;
  logic                   fire;

  logic                   active_r;
  logic [TIME_WIDTH-1:0]  last_act_r;
  logic [TIME_WIDTH-1:0]  first_enter_r;
  logic [TIME_WIDTH-1:0]  last_enter_r;

  cag_pkg::cag_out_item_t res;
  logic                   active_nxt;
  logic [TIME_WIDTH-1:0]  last_act_nxt;
  logic [TIME_WIDTH-1:0]  first_enter_nxt;
  logic [TIME_WIDTH-1:0]  last_enter_nxt;

  // Config port
  assign pready  = 1'b1;
  assign reg_idx = cag_pkg::cag_reg_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms         <= cag_pkg::DEBOUNCE_RST;
      cfg_r.enter_window_ms     <= cag_pkg::WINDOW_RST;
      cfg_r.inactivity_limit_ms <= cag_pkg::INACTIVE_RST;
      cfg_r.key_mask_low        <= '0;
      cfg_r.key_mask_high       <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        cag_pkg::REG_DEBOUNCE:  cfg_r.debounce_ms         <= pwdata[15:0];
        cag_pkg::REG_WINDOW:    cfg_r.enter_window_ms     <= pwdata[15:0];
        cag_pkg::REG_INACTIVE:  cfg_r.inactivity_limit_ms <= pwdata[31:0];
        cag_pkg::REG_MASK_LOW:  cfg_r.key_mask_low        <= pwdata;
        cag_pkg::REG_MASK_HIGH: cfg_r.key_mask_high       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cag_pkg::REG_DEBOUNCE:  prdata = cag_pkg::DATA_W'(cfg_r.debounce_ms);
      cag_pkg::REG_WINDOW:    prdata = cag_pkg::DATA_W'(cfg_r.enter_window_ms);
      cag_pkg::REG_INACTIVE:  prdata = cag_pkg::DATA_W'(cfg_r.inactivity_limit_ms);
      cag_pkg::REG_MASK_LOW:  prdata = cfg_r.key_mask_low;
      cag_pkg::REG_MASK_HIGH: prdata = cfg_r.key_mask_high;
      default:                prdata = '0;
    endcase
  end

  // Handshake
  assign fire         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || fire;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= res;
    end
  end

  // Console state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      last_act_r    <= '0;
      first_enter_r <= '0;
      last_enter_r  <= '0;
    end else if (fire) begin
      active_r      <= active_nxt;
      last_act_r    <= last_act_nxt;
      first_enter_r <= first_enter_nxt;
      last_enter_r  <= last_enter_nxt;
    end
  end

  cag_decide #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_decide (
    .cfg             (cfg_r),
    .item            (in_item_r),
    .active          (active_r),
    .last_act        (last_act_r),
    .first_enter     (first_enter_r),
    .last_enter      (last_enter_r),
    .res             (res),
    .active_nxt      (active_nxt),
    .last_act_nxt    (last_act_nxt),
    .first_enter_nxt (first_enter_nxt),
    .last_enter_nxt  (last_enter_nxt)
  );

  // Assertions
  `CAG_ASSERT_NOW(a_reject_not_accepted,
    out_valid_r && (out_item_r.action == cag_pkg::ACT_IGNORED ||
    out_item_r.action == cag_pkg::ACT_BAD_DEVICE),
    !out_item_r.accepted, "ignored or bad-device result marked accepted")
  `CAG_ASSERT_NOW(a_timeout_inactive_path,
    out_valid_r && out_item_r.auto_deactivated,
    out_item_r.action == cag_pkg::ACT_IGNORED ||
    out_item_r.action == cag_pkg::ACT_FIRST_ENTER ||
    out_item_r.action == cag_pkg::ACT_ACTIVATED ||
    out_item_r.action == cag_pkg::ACT_RESTART,
    "timed-out byte handled as active-console byte")
  `CAG_ASSERT_NEXT(a_activate_sets_state,
    fire && res.action == cag_pkg::ACT_ACTIVATED,
    active_r && first_enter_r == '0, "activation did not update console state")
  `CAG_ASSERT_NEXT(a_stall_holds_input,
    in_valid_r && !fire, in_valid_r, "stalled input transaction dropped")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console activation gate testbench
// Sends byte transactions with chosen timestamps through the gate, predicts
// every result transaction in a scoreboard and compares them field by field.
// Covers double-Enter activation, debounce, timeouts, key dispatch and device
// select under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------

module tb;
  import cag_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned N_RANDOM    = 1500;
  localparam int unsigned N_DIRECTED  = 24;

  class activation_tracker;
    logic [15:0]   debounce_ms   = DEBOUNCE_RST;
    logic [15:0]   window_ms     = WINDOW_RST;
    logic [31:0]   idle_limit_ms = INACTIVE_RST;
    logic [127:0]  key_mask      = '0;
    logic          active        = 1'b0;
    logic [31:0]   last_activity = '0;
    logic [31:0]   first_enter   = '0;
    logic [31:0]   last_enter    = '0;
    cag_out_item_t pending_outcomes[$];
    int unsigned   errors        = 0;
    int unsigned   checked       = 0;
    int unsigned   timeouts      = 0;
    int unsigned   action_hits[8];

    function void set_reg(cag_reg_t idx, logic [63:0] value);
      case (idx)
        REG_DEBOUNCE:  debounce_ms = value[15:0];
        REG_WINDOW:    window_ms = value[15:0];
        REG_INACTIVE:  idle_limit_ms = value[31:0];
        REG_MASK_LOW:  key_mask[63:0] = value;
        REG_MASK_HIGH: key_mask[127:64] = value;
        default: ;
      endcase
    endfunction

    function void note_byte(cag_in_item_t item);
      cag_out_item_t res;
      logic          is_enter;
      logic [31:0]   stamp;
      logic [7:0]    dev;
      stamp = item.now_ms;
      res = '0;
      res.action = ACT_IGNORED;
      is_enter = (item.rx_byte == BYTE_CR) || (item.rx_byte == BYTE_LF);
      if (active && last_activity != '0 && 32'(stamp - last_activity) > idle_limit_ms) begin
        active = 1'b0;
        first_enter = '0;
        res.auto_deactivated = 1'b1;
      end
      if (!active) begin
        if (is_enter && !(last_enter != '0 &&
            32'(stamp - last_enter) < {16'd0, debounce_ms})) begin
          last_enter = stamp;
          res.accepted = 1'b1;
          if (first_enter == '0) begin
            first_enter = stamp;
            res.action = ACT_FIRST_ENTER;
          end else if (32'(stamp - first_enter) <= {16'd0, window_ms}) begin
            active = 1'b1;
            first_enter = '0;
            last_activity = stamp;
            res.action = ACT_ACTIVATED;
          end else begin
            first_enter = stamp;
            res.action = ACT_RESTART;
          end
        end
      end else begin
        last_activity = stamp;
        if (!is_enter && item.rx_byte >= PRINT_LO && item.rx_byte <= PRINT_HI) begin
          if (key_mask[item.rx_byte[6:0]]) begin
            res.action = ACT_DISPATCH;
            res.accepted = 1'b1;
            res.key_code = item.rx_byte[6:0];
          end else if (item.rx_byte >= DIGIT_LO && item.rx_byte <= DIGIT_HI) begin
            dev = item.rx_byte - DIGIT_LO;
            res.device_index = dev[3:0];
            if (dev < item.device_count) begin
              res.action = ACT_SELECT;
              res.accepted = 1'b1;
            end else begin
              res.action = ACT_BAD_DEVICE;
            end
          end
        end
      end
      pending_outcomes.push_back(res);
    endfunction

    function void field_check(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(cag_out_item_t got);
      cag_out_item_t want;
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual action %0d", $time,
                 got.action);
        return;
      end
      want = pending_outcomes.pop_front();
      checked++;
      action_hits[want.action]++;
      timeouts += 32'(want.auto_deactivated);
      field_check("action", 32'(want.action), 32'(got.action));
      field_check("accepted", 32'(want.accepted), 32'(got.accepted));
      field_check("key_code", 32'(want.key_code), 32'(got.key_code));
      field_check("device_index", 32'(want.device_index), 32'(got.device_index));
      field_check("auto_deactivated", 32'(want.auto_deactivated),
                  32'(got.auto_deactivated));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  cag_stream_if #(.payload_t(cag_in_item_t))  byte_ch ();
  cag_stream_if #(.payload_t(cag_out_item_t)) result_ch ();

  activation_tracker tracker = new();

  int unsigned sent           = 0;
  int unsigned settings_count = 0;
  logic [31:0] clock_ms       = '0;
  bit          sender_gaps    = 1'b0;
  bit          sink_stalls    = 1'b0;
  bit          hold_request   = 1'b0;

  console_activation_gate DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (byte_ch),
    .out_ch  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && result_ch.valid && result_ch.ready) begin
      tracker.check_result(result_ch.data);
    end
  end

  // receiver: ready bursts, random stalls, and one long hold on request
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("tb: run timed out");
    $display("tb: failure");
    $finish;
  end

  task automatic send_byte(logic [7:0] rx, logic [31:0] stamp, logic [7:0] count);
    cag_in_item_t item;
    item.rx_byte      = rx;
    item.now_ms       = stamp;
    item.device_count = count;
    byte_ch.valid <= 1'b1;
    byte_ch.data  <= item;
    do @(posedge clk); while (!byte_ch.ready);
    tracker.note_byte(item);
    sent++;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    while (tracker.pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(cag_reg_t idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(8 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    tracker.set_reg(idx, value);
  endtask

  task automatic apb_read(cag_reg_t idx, output logic [63:0] data_out);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(8 * int'(idx));
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data_out = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_checked(cag_reg_t idx, logic [63:0] value);
    logic [63:0] keep;
    logic [63:0] seen;
    case (idx)
      REG_DEBOUNCE, REG_WINDOW: keep = 64'hFFFF;
      REG_INACTIVE:             keep = 64'hFFFF_FFFF;
      default:                  keep = '1;
    endcase
    apb_write(idx, value);
    apb_read(idx, seen);
    if ((seen & keep) !== (value & keep)) begin
      tracker.errors++;
      $display("%0t: register %s readback mismatch, expected %0h, actual %0h", $time,
               idx.name(), value & keep, seen & keep);
    end
  endtask

  task automatic apply_settings(logic [15:0] debounce, logic [15:0] window,
                                logic [31:0] idle_limit, logic [63:0] mask_lo,
                                logic [63:0] mask_hi);
    wait_idle();
    write_checked(REG_DEBOUNCE, {48'd0, debounce});
    write_checked(REG_WINDOW, {48'd0, window});
    write_checked(REG_INACTIVE, {32'd0, idle_limit});
    write_checked(REG_MASK_LOW, mask_lo);
    write_checked(REG_MASK_HIGH, mask_hi);
    settings_count++;
  endtask

  function automatic logic [7:0] any_enter();
    return $urandom_range(0, 1) ? BYTE_CR : BYTE_LF;
  endfunction

  function automatic logic [7:0] device_total();
    return 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10));
  endfunction

  function automatic logic [7:0] active_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'(DIGIT_LO + $urandom_range(0, 8));
      3, 4, 5: return 8'($urandom_range(PRINT_LO, PRINT_HI));
      6:       return any_enter();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void jump_clock();
    case ($urandom_range(0, 7))
      0:       clock_ms = $urandom;
      1:       clock_ms = '0;
      2:       clock_ms = clock_ms - $urandom_range(1, 1000);
      3:       clock_ms = clock_ms + tracker.idle_limit_ms + 1;
      4:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      default: clock_ms = clock_ms + $urandom_range(0, 3000);
    endcase
  endfunction

  // mostly enter pairs followed by an active stretch, some line noise
  task automatic run_session();
    logic [31:0] lead;
    logic [31:0] span;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        jump_clock();
        send_byte(8'($urandom_range(0, 255)), clock_ms, device_total());
      end
    end else begin
      if ($urandom_range(0, 3) == 0) jump_clock();
      else clock_ms = clock_ms + tracker.debounce_ms + $urandom_range(0, 100);
      lead = clock_ms;
      send_byte(any_enter(), clock_ms, device_total());
      if ($urandom_range(0, 2) == 0) begin
        clock_ms = clock_ms + $urandom_range(0, tracker.debounce_ms);
        send_byte(any_enter(), clock_ms, device_total());
      end
      if (tracker.window_ms >= tracker.debounce_ms)
        span = $urandom_range(tracker.debounce_ms, tracker.window_ms);
      else
        span = $urandom_range(0, tracker.window_ms);
      if ($urandom_range(0, 5) == 0) span = tracker.window_ms + 1 + $urandom_range(0, 500);
      clock_ms = lead + span;
      send_byte(any_enter(), clock_ms, device_total());
      repeat ($urandom_range(3, 14)) begin
        clock_ms = clock_ms + $urandom_range(0, (tracker.idle_limit_ms < 2000) ?
                                                tracker.idle_limit_ms : 2000);
        send_byte(active_byte(), clock_ms, device_total());
      end
      if ($urandom_range(0, 3) == 0) begin
        clock_ms = clock_ms + tracker.idle_limit_ms + 1 + $urandom_range(0, 3);
        send_byte(active_byte(), clock_ms, device_total());
      end
    end
  endtask

  initial begin
    int unsigned p;
    byte_ch.valid <= 1'b0;
    byte_ch.data  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_n         <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // '5' and BEL marked low, 'h' and DEL marked high
    apply_settings(DEBOUNCE_RST, WINDOW_RST, INACTIVE_RST,
                   (64'd1 << 8'h35) | (64'd1 << 8'h07),
                   (64'd1 << (8'h68 - 64)) | (64'd1 << (8'h7F - 64)));
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    send_byte(BYTE_CR, 32'd0, 8'd3);
    send_byte(BYTE_LF, 32'd50, 8'd3);
    send_byte(BYTE_CR, 32'd80, 8'd3);
    send_byte("A", 32'd90, 8'd3);
    send_byte(BYTE_LF, 32'd2000, 8'd3);
    send_byte(BYTE_CR, 32'd2100, 8'd3);
    send_byte(BYTE_CR, 32'd2200, 8'd3);
    send_byte("5", 32'd2300, 8'd3);
    send_byte("1", 32'd2400, 8'd3);
    send_byte("9", 32'd2500, 8'd255);
    send_byte("4", 32'd2600, 8'd3);
    send_byte("1", 32'd2700, 8'd0);
    send_byte(8'h07, 32'd2800, 8'd3);
    send_byte(8'h7F, 32'd2900, 8'd3);
    send_byte(8'hFF, 32'd3000, 8'd3);
    send_byte("h", 32'd3100, 8'd3);
    send_byte(PRINT_LO, 32'd3200, 8'd3);
    send_byte(PRINT_HI, 32'd3250, 8'd3);
    send_byte("A", 32'd303251, 8'd3);
    send_byte(BYTE_CR, 32'd303300, 8'd3);
    send_byte(BYTE_LF, 32'd303450, 8'd3);
    send_byte(BYTE_CR, 32'hFFFF_FF00, 8'd3);
    send_byte(BYTE_LF, 32'h0000_0010, 8'd3);
    send_byte("3", 32'h0000_0020, 8'd4);
    clock_ms = 32'h20;

    for (p = 0; p < 10; p++) begin
      case (p)
        0: apply_settings(DEBOUNCE_RST, WINDOW_RST, 32'd3000,
                          {$urandom, $urandom}, {$urandom, $urandom});
        1: apply_settings(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, '1, '1);
        2: apply_settings('0, '0, '0, '0, '0);
        9: apply_settings(DEBOUNCE_RST, WINDOW_RST, INACTIVE_RST,
                          {$urandom, $urandom}, {$urandom, $urandom});
        default: apply_settings(16'($urandom_range(0, 400)), 16'($urandom_range(0, 3000)),
                                ($urandom_range(0, 3) == 0) ? $urandom
                                                            : $urandom_range(0, 8000),
                                {$urandom, $urandom} & {$urandom, $urandom},
                                {$urandom, $urandom} & {$urandom, $urandom});
      endcase
      sender_gaps = (p < 8) && ($urandom_range(0, 2) != 0);
      sink_stalls = (p < 8) && ($urandom_range(0, 2) != 0);
      if (p == 4) begin
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        repeat (24) begin
          clock_ms = clock_ms + $urandom_range(0, 20);
          send_byte(active_byte(), clock_ms, device_total());
        end
      end
      while (sent < N_DIRECTED + (p + 1) * N_RANDOM / 10) run_session();
    end

    wait_idle();
    repeat (6) @(posedge clk);
    $display("tb: %0d byte transactions checked under %0d register settings, %0d timeouts",
             tracker.checked, settings_count, tracker.timeouts);
    $display("tb: %0d activations, %0d dispatches, %0d selects, %0d bad device picks",
             tracker.action_hits[ACT_ACTIVATED], tracker.action_hits[ACT_DISPATCH],
             tracker.action_hits[ACT_SELECT], tracker.action_hits[ACT_BAD_DEVICE]);
    if (tracker.errors == 0 && tracker.pending_outcomes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
